/* hdl/fpdr_pkg.sv */
// Shared types and constants for the fixed-point divider with rounding.
// Used by every module of the block; depends on nothing.
`default_nettype none

package fpdr_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FracW  = 6;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CountW = 7;
  localparam int unsigned ApbAw  = 3;
  localparam int unsigned ApbDw  = 32;

  localparam logic [ModeW-1:0] RND_DOWN    = 2'd0;
  localparam logic [ModeW-1:0] RND_UP      = 2'd1;
  localparam logic [ModeW-1:0] RND_NEAREST = 2'd2;

  localparam logic REG_FRAC = 1'b0;
  localparam logic REG_MODE = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic round;
  } fpdr_cmd_t;

endpackage

`default_nettype wire

/* hdl/fpdr_regs.sv */
// Configuration registers (fraction_bits, rounding_mode) behind an APB-style port.
// Depends on fpdr_pkg.
`default_nettype none

module fpdr_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fpdr_pkg::ApbAw-1:0]  paddr,
  input  wire logic [fpdr_pkg::ApbDw-1:0]  pwdata,
  output logic      [fpdr_pkg::ApbDw-1:0]  prdata,
  output logic                             pready,
  output logic      [fpdr_pkg::FracW-1:0]  frac_bits_o,
  output logic      [fpdr_pkg::ModeW-1:0]  round_mode_o
);
  import fpdr_pkg::*;

  logic [FracW-1:0] frac_q;
  logic [ModeW-1:0] mode_q;
  logic             wr_en;
  logic             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frac_q <= '0;
      mode_q <= RND_DOWN;
    end else if (wr_en) begin
      case (reg_sel)
        REG_FRAC: frac_q <= pwdata[FracW-1:0];
        REG_MODE: mode_q <= pwdata[ModeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_FRAC: prdata = {{(ApbDw-FracW){1'b0}}, frac_q};
      REG_MODE: prdata = {{(ApbDw-ModeW){1'b0}}, mode_q};
      default:  prdata = '0;
    endcase
  end

  assign frac_bits_o  = frac_q;
  assign round_mode_o = mode_q;

endmodule

`default_nettype wire

/* hdl/fpdr_ctrl.sv */
// Controller: sequences load, restoring-divide steps and rounding, owns the output valid.
// Depends on fpdr_pkg.
`default_nettype none

module fpdr_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_valid_i,
  output logic                             s_ready_o,
  output logic                             m_valid_o,
  input  wire logic                        m_ready_i,
  input  wire logic [fpdr_pkg::FracW-1:0]  frac_bits_i,
  output fpdr_pkg::fpdr_cmd_t              cmd_o
);
  import fpdr_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              valid_q, valid_d;
  fpdr_cmd_t         cmd;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd.load = 1'b1;
          cnt_d    = CountW'(DataW) + {1'b0, frac_bits_i};
          state_d  = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == CountW'(1)) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!valid_q || m_ready_i) begin
          cmd.round = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q & ~m_ready_i;
    if (cmd.round) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      valid_q <= valid_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = valid_q;
  assign cmd_o     = cmd;

endmodule

`default_nettype wire

/* hdl/fpdr_dpath.sv */
// Datapath: radix-2 restoring divider registers, rounding stage and result register.
// Depends on fpdr_pkg; driven by fpdr_ctrl commands.
`default_nettype none

module fpdr_dpath (
  input  wire logic                        clk_i,
  input  wire fpdr_pkg::fpdr_cmd_t         cmd_i,
  input  wire logic [fpdr_pkg::DataW-1:0]  dividend_i,
  input  wire logic [fpdr_pkg::DataW-1:0]  divisor_i,
  input  wire logic [fpdr_pkg::ModeW-1:0]  round_mode_i,
  output logic      [fpdr_pkg::DataW-1:0]  quotient_o,
  output logic                             div_zero_o
);
  import fpdr_pkg::*;

  logic [DataW-1:0] num_q;
  logic [DataW-1:0] div_q;
  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] quo_q;
  logic [DataW-1:0] res_q;
  logic             dbz_q;

  logic             carry;
  logic [DataW-1:0] rem_sh;
  logic [DataW:0]   diff;
  logic             take;

  logic [DataW-1:0] half;
  logic             inc;
  logic             set_low;
  logic [DataW-1:0] rounded;
  logic             div_zero;

  assign carry  = rem_q[DataW-1];
  assign rem_sh = {rem_q[DataW-2:0], num_q[DataW-1]};
  assign diff   = {1'b0, rem_sh} - {1'b0, div_q};
  assign take   = carry | ~diff[DataW];

  always_comb begin
    half     = {1'b0, div_q[DataW-1:1]};
    div_zero = (div_q == '0);
    inc      = 1'b0;
    set_low  = 1'b0;
    case (round_mode_i)
      RND_UP:      inc = (rem_q != '0);
      RND_NEAREST: begin
        inc     = (rem_q > half);
        set_low = (rem_q == half) & ~div_q[0];
      end
      default: ;
    endcase
    rounded = quo_q + {{(DataW-1){1'b0}}, inc};
    if (set_low) begin
      rounded[0] = 1'b1;
    end
    if (div_zero) begin
      rounded = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      num_q <= dividend_i;
      div_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.step) begin
      num_q <= {num_q[DataW-2:0], 1'b0};
      rem_q <= take ? diff[DataW-1:0] : rem_sh;
      quo_q <= {quo_q[DataW-2:0], take};
    end
    if (cmd_i.round) begin
      res_q <= rounded;
      dbz_q <= div_zero;
    end
  end

  assign quotient_o = res_q;
  assign div_zero_o = dbz_q;

endmodule

`default_nettype wire

/* hdl/fixed_point_divider_rounding.sv */
// Top level of the fixed-point divider with rounding.
// Depends on fpdr_pkg, fpdr_regs, fpdr_ctrl and fpdr_dpath.
//
// Each input word carries an unsigned dividend and divisor; the block returns
// floor, ceiling or nearest-ties-to-odd of (dividend * 2^fraction_bits) / divisor,
// wrapped to 64 bits, with divide_by_zero set and a zero quotient for a zero
// divisor. A new word is taken only once the last one is through: the
// cycle that accepts and loads it, the one-bit-per-cycle restoring subtract
// loop, which shifts in the 64 dividend bits and then fraction_bits zeros, and
// the rounding state, which holds while an earlier result still waits to be read.
// The result is written in the rounding state and sits in an output
// register, so the next word is taken while it waits.
`default_nettype none

module fixed_point_divider_rounding (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // tdata: dividend_value [63:0], divisor_value [127:64]
  input  wire logic [2*fpdr_pkg::DataW-1:0] s_axis_tdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: quotient_value [63:0]
  output logic      [fpdr_pkg::DataW-1:0]  m_axis_tdata_o,
  // tuser: divide_by_zero [0]
  output logic                             m_axis_tuser_o,
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fpdr_pkg::ApbAw-1:0]  paddr,
  input  wire logic [fpdr_pkg::ApbDw-1:0]  pwdata,
  output logic      [fpdr_pkg::ApbDw-1:0]  prdata,
  output logic                             pready
);
  import fpdr_pkg::*;

  logic [FracW-1:0] frac_bits;
  logic [ModeW-1:0] round_mode;
  fpdr_cmd_t        cmd;

  fpdr_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frac_bits_o  (frac_bits),
    .round_mode_o (round_mode)
  );

  fpdr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .frac_bits_i (frac_bits),
    .cmd_o       (cmd)
  );

  fpdr_dpath u_dpath (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .dividend_i   (s_axis_tdata_i[DataW-1:0]),
    .divisor_i    (s_axis_tdata_i[2*DataW-1:DataW]),
    .round_mode_i (round_mode),
    .quotient_o   (m_axis_tdata_o),
    .div_zero_o   (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

/* hdl/fpdr_checker.sv */
// Port-level checks for the fixed-point divider with rounding, bound to the top level.
// Depends on fpdr_pkg and fixed_point_divider_rounding.
`default_nettype none

module fpdr_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         s_axis_tvalid_i,
  input wire logic                         s_axis_tready_o,
  input wire logic [fpdr_pkg::DataW-1:0]   m_axis_tdata_o,
  input wire logic                         m_axis_tuser_o,
  input wire logic                         m_axis_tvalid_o,
  input wire logic                         m_axis_tready_i
);
  import fpdr_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input ready after a word was taken");

  a_result_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("result raised while input side idle");

  a_zero_div_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("nonzero quotient with divide by zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("output word dropped while stalled");

endmodule

bind fixed_point_divider_rounding fpdr_checker u_fpdr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i)
);

`default_nettype wire
